@@ hdl/line_comment_stripper_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line comment stripper
// Shared concurrent check forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef LINE_COMMENT_STRIPPER_UNIT_MACROS_SVH
`define LINE_COMMENT_STRIPPER_UNIT_MACROS_SVH

// condition must never hold
`define LCS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// same-cycle implication
`define LCS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Character codes, line mode codes and result bundle types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  localparam int unsigned MAX_SPACE_RUN_DEF = 255;
  localparam int unsigned NUM_RES = 3;

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_SPACE  = 8'd32;

  typedef enum logic [1:0] {
    SUP_NONE = 2'd0,
    SUP_REST = 2'd1,
    SUP_DROP = 2'd2
  } lcs_sup_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] lead_spaces;
    logic       done_res;
  } lcs_res_t;

  typedef struct packed {
    logic                 load;
    logic [1:0]           cnt;
    lcs_res_t [NUM_RES-1:0] res;
  } lcs_bundle_t;

endpackage

`default_nettype wire

@@ hdl/lcs_if.sv @@
// ----------------------------------------------------------------------------
// lcs_in_if / lcs_out_if
// Valid/ready channels for text words in and filtered words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, output in_byte, output end_mark, input ready);
  modport sink (input valid, input in_byte, input end_mark, output ready);
endinterface

interface lcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] lead_spaces;
  logic       done_res;
  logic       last_of_step;

  modport source (
    output valid, output out_byte, output lead_spaces, output done_res,
    output last_of_step, input ready
  );
  modport sink (
    input valid, input out_byte, input lead_spaces, input done_res,
    input last_of_step, output ready
  );
endinterface

`default_nettype wire

@@ hdl/lcs_core.sv @@
// ----------------------------------------------------------------------------
// lcs_core
// Input register, line state and single-pass filter logic per text word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcs_core #(
  parameter int unsigned MAX_SPACE_RUN = lcs_pkg::MAX_SPACE_RUN_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  lcs_in_if.sink                  in_i,
  input  wire logic               load_ok_i,
  output lcs_pkg::lcs_bundle_t    bundle_o
);
  import lcs_pkg::*;

  `include "line_comment_stripper_unit_macros.svh"

  localparam int unsigned HW = $clog2(MAX_SPACE_RUN + 1);
  localparam logic [HW-1:0] HELD_MAX = HW'(MAX_SPACE_RUN);

  typedef struct packed {
    logic          blk;
    logic          quote;
    logic          all_sp;
    lcs_sup_e      sup;
    logic          slash;
    logic          star;
    logic          bodd;
    logic          pcr;
    logic [HW-1:0] held;
  } lcs_st_t;

  localparam lcs_st_t ST_RESET = '{
    blk: 1'b0, quote: 1'b0, all_sp: 1'b1, sup: SUP_NONE, slash: 1'b0,
    star: 1'b0, bodd: 1'b0, pcr: 1'b0, held: '0
  };

  function automatic logic [7:0] lead_of(logic [HW-1:0] h);
    logic [HW+7:0] w;
    w = {8'd0, h};
    return w[7:0];
  endfunction

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  lcs_st_t    st_q, st_d;
  lcs_res_t [NUM_RES-1:0] res;
  logic [1:0] n;
  logic       adv;

  always_comb begin
    lcs_st_t s;
    logic    do_end;
    logic    skip;
    s      = st_q;
    res    = '0;
    n      = 2'd0;
    skip   = 1'b0;
    if (end_q) begin
      do_end = !(s.all_sp && (s.held == '0) && !s.slash && (s.sup == SUP_NONE));
    end else if (byte_q == CH_CR) begin
      do_end = 1'b1;
    end else if (byte_q == CH_LF) begin
      do_end = !s.pcr;
    end else begin
      do_end = 1'b0;
    end
    if (do_end) begin
      if (s.sup != SUP_DROP) begin
        if (s.slash) begin
          res[n] = '{out_byte: CH_SLASH, lead_spaces: lead_of(s.held), done_res: 1'b0};
          n = n + 2'd1;
        end
        res[n] = '{out_byte: CH_LF, lead_spaces: 8'd0, done_res: 1'b0};
        n = n + 2'd1;
      end
      s.quote  = 1'b0;
      s.all_sp = 1'b1;
      s.sup    = SUP_NONE;
      s.slash  = 1'b0;
      s.star   = 1'b0;
      s.bodd   = 1'b0;
      s.held   = '0;
    end
    if (end_q) begin
      res[n] = '{out_byte: 8'd0, lead_spaces: 8'd0, done_res: 1'b1};
      n = n + 2'd1;
      s = ST_RESET;
    end else if (byte_q == CH_CR) begin
      s.pcr = 1'b1;
    end else if (byte_q == CH_LF) begin
      s.pcr = 1'b0;
    end else begin
      s.pcr = 1'b0;
      if (s.slash) begin
        s.slash = 1'b0;
        if (byte_q == CH_SLASH) begin
          s.sup  = s.all_sp ? SUP_DROP : SUP_REST;
          s.held = '0;
          skip   = 1'b1;
        end else begin
          res[n] = '{out_byte: CH_SLASH, lead_spaces: lead_of(s.held), done_res: 1'b0};
          n = n + 2'd1;
          s.held   = '0;
          s.all_sp = 1'b0;
          s.bodd   = 1'b0;
          if (byte_q == CH_STAR) begin
            res[n] = '{out_byte: CH_STAR, lead_spaces: 8'd0, done_res: 1'b0};
            n = n + 2'd1;
            s.blk  = 1'b1;
            s.star = 1'b0;
            skip   = 1'b1;
          end
        end
      end
      if (!skip && (s.sup == SUP_NONE)) begin
        if (byte_q == CH_SPACE) begin
          if (s.held < HELD_MAX) begin
            s.held = s.held + 1'b1;
          end
          s.bodd = 1'b0;
          s.star = 1'b0;
        end else if (!s.blk && !s.quote && (byte_q == CH_SLASH)) begin
          s.slash = 1'b1;
          s.bodd  = 1'b0;
        end else begin
          if (s.blk) begin
            if (s.star && (byte_q == CH_SLASH)) begin
              s.blk  = 1'b0;
              s.star = 1'b0;
            end else begin
              s.star = (byte_q == CH_STAR);
            end
          end else if ((byte_q == CH_QUOTE) && !s.bodd) begin
            s.quote = !s.quote;
          end
          res[n] = '{out_byte: byte_q, lead_spaces: lead_of(s.held), done_res: 1'b0};
          n = n + 2'd1;
          s.held   = '0;
          s.all_sp = 1'b0;
          s.bodd   = (byte_q == CH_BSLASH) ? !s.bodd : 1'b0;
        end
      end
    end
    st_d = s;
  end

  assign adv        = in_valid_q && ((n == 2'd0) || load_ok_i);
  assign in_i.ready = !in_valid_q || adv;

  assign bundle_o.load = adv && (n != 2'd0);
  assign bundle_o.cnt  = n;
  assign bundle_o.res  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= ST_RESET;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
      end_q  <= in_i.end_mark;
    end
  end

  `LCS_ASSERT_NEVER(a_held_range, st_q.held > HELD_MAX, "space run above limit")
  `LCS_ASSERT_IMPL(a_slash_mode, st_q.slash, st_q.sup == SUP_NONE, "slash held in comment")
  `LCS_ASSERT_NEXT(a_stall_hold, in_valid_q && !adv, in_valid_q && $stable(byte_q), "lost word")

endmodule

`default_nettype wire

@@ hdl/lcs_outbuf.sv @@
// ----------------------------------------------------------------------------
// lcs_outbuf
// Result register: hold up to three results of one word and drain them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcs_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  lcs_pkg::lcs_bundle_t   bundle_i,
  output logic                   load_ok_o,
  lcs_out_if.source              out_o
);
  import lcs_pkg::*;

  `include "line_comment_stripper_unit_macros.svh"

  logic                   bv_q;
  logic [1:0]             cnt_q;
  logic [1:0]             ptr_q;
  lcs_res_t [NUM_RES-1:0] res_q;
  lcs_res_t               cur;
  logic                   last;
  logic                   pop;
  logic                   fin;

  assign cur  = res_q[ptr_q];
  assign last = (ptr_q == (cnt_q - 2'd1));
  assign pop  = bv_q && out_o.ready;
  assign fin  = pop && last;

  assign load_ok_o          = !bv_q || fin;
  assign out_o.valid        = bv_q;
  assign out_o.out_byte     = cur.out_byte;
  assign out_o.lead_spaces  = cur.lead_spaces;
  assign out_o.done_res     = cur.done_res;
  assign out_o.last_of_step = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q  <= 1'b0;
      cnt_q <= 2'd0;
      ptr_q <= 2'd0;
    end else if (bundle_i.load) begin
      bv_q  <= 1'b1;
      cnt_q <= bundle_i.cnt;
      ptr_q <= 2'd0;
    end else if (fin) begin
      bv_q  <= 1'b0;
    end else if (pop) begin
      ptr_q <= ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bundle_i.load) begin
      res_q <= bundle_i.res;
    end
  end

  `LCS_ASSERT_NEVER(a_cnt_zero, bv_q && (cnt_q == 2'd0), "empty result set held")
  `LCS_ASSERT_NEVER(a_ptr_range, bv_q && (ptr_q >= cnt_q), "drain pointer past count")
  `LCS_ASSERT_NEVER(a_load_busy, bundle_i.load && !load_ok_o, "results overwritten")

endmodule

`default_nettype wire

@@ hdl/line_comment_stripper_unit.sv @@
// A word passes the input reg, then the result reg, before its first result.
// Throughput: one word per cycle while the output is ready and each word yields
// at most one result; more results per word hold the single output port in turn.
// Reset: async active low; clears line and comment flags, space count, queues.
// ----------------------------------------------------------------------------
// line_comment_stripper_unit
// Stream filter dropping line comments, trailing spaces; CR line ends become LF.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_comment_stripper_unit #(
  parameter int unsigned MAX_SPACE_RUN = lcs_pkg::MAX_SPACE_RUN_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lcs_in_if.sink    in_i,
  lcs_out_if.source out_o
);
  import lcs_pkg::*;

  lcs_bundle_t bundle;
  logic        load_ok;

  lcs_core #(
    .MAX_SPACE_RUN (MAX_SPACE_RUN)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .load_ok_i (load_ok),
    .bundle_o  (bundle)
  );

  lcs_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bundle_i  (bundle),
    .load_ok_o (load_ok),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
